// ===== hw/rtl/delay_tagged_midi_stream_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
`ifndef DELAY_TAGGED_MIDI_STREAM_PARSER_DEFINES_SVH
`define DELAY_TAGGED_MIDI_STREAM_PARSER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define DTMSP_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in this cycle that implies another in the next cycle.
`define DTMSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dtmsp_pkg.sv =====
package dtmsp_pkg;

  // Result kinds carried on out_tuser.
  typedef enum logic [1:0] {
    KIND_SHORT = 2'd0,
    KIND_SYNC  = 2'd1,
    KIND_END   = 2'd2
  } event_kind_t;

  // Byte codes of the event stream.
  localparam logic [7:0] DELAY_END_CODE  = 8'hFF;
  localparam logic [7:0] DELAY_SYNC_CODE = 8'hF8;
  localparam logic [7:0] CMD_END_CODE    = 8'hFC;
  localparam logic [3:0] SYSTEM_NIBBLE   = 4'hF;
  localparam logic [2:0] ONE_DATA_TOP    = 3'b110;

  // Channel messages in the 0xC0-0xDF range carry a single data byte.
  function automatic logic needs_second(input logic [7:0] status);
    needs_second = (status[7:5] != ONE_DATA_TOP);
  endfunction

endpackage

// ===== hw/rtl/delay_tagged_midi_stream_parser.sv =====
// Parses a delay-tagged MIDI event stream at one byte per clock cycle. Each
// accepted input item is one stream byte (in_tdata) with a song-start flag
// (in_tuser) that clears the parser before that byte is taken. A byte is held
// in the input register and is parsed from there into the result register. A
// new byte is taken every cycle as long as the result side keeps up; a stalled
// result holds the input register, which then stalls the input side. A byte
// yields zero or one result: a short message (kind 0) with its delay and
// status | d1<<8 | d2<<16, a sync event (kind 1) with its delay, or end of
// stream (kind 2) with zero fields. After end of stream, bytes are absorbed
// with no result until a byte arrives with the song-start flag set.
module delay_tagged_midi_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic [0:0]  in_tuser,   // [0] song_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] event_delay, [31:8] short_message
  output logic [1:0]  out_tuser   // [1:0] event_kind
);
  import dtmsp_pkg::*;

  `include "delay_tagged_midi_stream_parser_defines.svh"

  typedef enum logic [2:0] {
    PH_DELAY = 3'd0,
    PH_CMD   = 3'd1,
    PH_DATA1 = 3'd2,
    PH_DATA2 = 3'd3,
    PH_ENDED = 3'd4
  } phase_t;

  // Input register.
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  delay_r, delay_nxt;
  logic [15:0] partial_r, partial_nxt;

  // Result register.
  logic        out_valid_r;
  logic [7:0]  out_delay_r;
  logic [23:0] out_msg_r;
  event_kind_t out_kind_r;

  // Combinational result of the byte in the input register.
  logic        emit;
  event_kind_t kind_nxt;
  logic [7:0]  ev_delay_nxt;
  logic [23:0] msg_nxt;

  // Effective state after an optional song start.
  phase_t      cur_phase;
  logic [7:0]  cur_status;
  logic [7:0]  cur_delay;
  logic [15:0] cur_partial;

  logic        advance;

  // The parsed byte moves on when the result slot is free or being emptied.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Parse one byte.
  always_comb begin
    cur_phase   = in_start_r ? PH_DELAY : phase_r;
    cur_status  = in_start_r ? 8'h00 : status_r;
    cur_delay   = in_start_r ? 8'h00 : delay_r;
    cur_partial = in_start_r ? 16'h0000 : partial_r;

    phase_nxt    = cur_phase;
    status_nxt   = cur_status;
    delay_nxt    = cur_delay;
    partial_nxt  = cur_partial;
    emit         = 1'b0;
    kind_nxt     = KIND_SHORT;
    ev_delay_nxt = 8'h00;
    msg_nxt      = 24'h000000;

    case (cur_phase)
      PH_DELAY: begin
        if (in_byte_r == DELAY_END_CODE) begin
          phase_nxt = PH_ENDED;
          emit      = 1'b1;
          kind_nxt  = KIND_END;
        end else if (in_byte_r == DELAY_SYNC_CODE) begin
          emit         = 1'b1;
          kind_nxt     = KIND_SYNC;
          ev_delay_nxt = in_byte_r;
        end else begin
          delay_nxt = in_byte_r;
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        if (in_byte_r == CMD_END_CODE) begin
          phase_nxt = PH_ENDED;
          emit      = 1'b1;
          kind_nxt  = KIND_END;
        end else if (in_byte_r[7:4] == SYSTEM_NIBBLE) begin
          phase_nxt    = PH_DELAY;
          emit         = 1'b1;
          kind_nxt     = KIND_SYNC;
          ev_delay_nxt = cur_delay;
        end else if (in_byte_r[7]) begin
          // New status byte: becomes the running status.
          status_nxt  = in_byte_r;
          partial_nxt = {8'h00, in_byte_r};
          phase_nxt   = PH_DATA1;
        end else if (cur_status == 8'h00) begin
          // Data byte with no running status is dropped.
          phase_nxt = PH_DELAY;
        end else begin
          partial_nxt = {in_byte_r, cur_status};
          if (needs_second(cur_status)) begin
            phase_nxt = PH_DATA2;
          end else begin
            phase_nxt    = PH_DELAY;
            emit         = 1'b1;
            ev_delay_nxt = cur_delay;
            msg_nxt      = {8'h00, in_byte_r, cur_status};
          end
        end
      end
      PH_DATA1: begin
        partial_nxt = {in_byte_r, cur_partial[7:0]};
        if (needs_second(cur_partial[7:0])) begin
          phase_nxt = PH_DATA2;
        end else begin
          phase_nxt    = PH_DELAY;
          emit         = 1'b1;
          ev_delay_nxt = cur_delay;
          msg_nxt      = {8'h00, in_byte_r, cur_partial[7:0]};
        end
      end
      PH_DATA2: begin
        phase_nxt    = PH_DELAY;
        emit         = 1'b1;
        ev_delay_nxt = cur_delay;
        msg_nxt      = {in_byte_r, cur_partial};
      end
      default: begin
        // End of stream: bytes are absorbed until a song start.
        phase_nxt = PH_ENDED;
      end
    endcase
  end

  // Input register, parser state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_DELAY;
      status_r    <= 8'h00;
      delay_r     <= 8'h00;
      partial_r   <= 16'h0000;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        phase_r     <= phase_nxt;
        status_r    <= status_nxt;
        delay_r     <= delay_nxt;
        partial_r   <= partial_nxt;
        out_valid_r <= emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
    if (advance && emit) begin
      out_kind_r  <= kind_nxt;
      out_delay_r <= ev_delay_nxt;
      out_msg_r   <= msg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_msg_r, out_delay_r};
  assign out_tuser  = out_kind_r;

  // Assertions.
  `DTMSP_ASSERT_NEXT(a_ended_sticks, advance && !in_start_r && phase_r == PH_ENDED, phase_r == PH_ENDED, "parser left end of stream without a song start")
  `DTMSP_ASSERT_HOLDS(a_end_zero, !(out_valid_r && out_kind_r == KIND_END) || out_tdata == 32'h0, "end result carries nonzero fields")
  `DTMSP_ASSERT_HOLDS(a_sync_no_msg, !(out_valid_r && out_kind_r == KIND_SYNC) || out_msg_r == 24'h0, "sync result carries a message")
  `DTMSP_ASSERT_HOLDS(a_data_has_status, !(phase_r == PH_DATA1 || phase_r == PH_DATA2) || partial_r[7], "data phase without a status byte")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dtmsp_pkg::*;

  // One result as it leaves the parser.
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  delay;
    logic [23:0] message;
  } midi_event_t;

  // Where the parser stands inside the current event.
  typedef enum logic [2:0] {
    WAIT_DELAY   = 3'd0,
    WAIT_COMMAND = 3'd1,
    WAIT_DATA1   = 3'd2,
    WAIT_DATA2   = 3'd3,
    STREAM_ENDED = 3'd4
  } parse_phase_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] STATUS_FIRST = 8'h80;
  localparam logic [7:0] STATUS_LAST = 8'hEF;
  localparam logic [7:0] DATA_LAST = 8'h7F;
  localparam logic [7:0] SYSTEM_FIRST = 8'hF0;
  localparam logic [7:0] NO_STATUS = 8'h00;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shadow copy of the parser state.
  parse_phase_t shadow_phase = WAIT_DELAY;
  logic [7:0]   shadow_status = NO_STATUS;
  logic [7:0]   shadow_delay = 8'h00;
  logic [15:0]  shadow_partial = 16'h0000;

  midi_event_t pending_events[$];
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned short_seen = 0;
  int unsigned sync_seen = 0;
  int unsigned end_seen = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  delay_tagged_midi_stream_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Statuses in the 0xC0-0xDF range take a single data byte.
  function automatic logic takes_two_data(input logic [7:0] status);
    return status[7:5] != ONE_DATA_TOP;
  endfunction

  // Advances the shadow state by one accepted byte and reports the event it yields.
  function automatic logic parse_stream_byte(input logic [7:0] b, input logic restart,
                                             output midi_event_t ev);
    logic produced;
    produced = 1'b0;
    ev = '{kind: KIND_SHORT, delay: 8'h00, message: 24'h000000};
    if (restart) begin
      shadow_phase = WAIT_DELAY;
      shadow_status = NO_STATUS;
      shadow_delay = 8'h00;
      shadow_partial = 16'h0000;
    end
    case (shadow_phase)
      WAIT_DELAY: begin
        if (b == DELAY_END_CODE) begin
          shadow_phase = STREAM_ENDED;
          ev.kind = KIND_END;
          produced = 1'b1;
        end else if (b == DELAY_SYNC_CODE) begin
          ev.kind = KIND_SYNC;
          ev.delay = b;
          produced = 1'b1;
        end else begin
          shadow_delay = b;
          shadow_phase = WAIT_COMMAND;
        end
      end
      WAIT_COMMAND: begin
        if (b == CMD_END_CODE) begin
          shadow_phase = STREAM_ENDED;
          ev.kind = KIND_END;
          produced = 1'b1;
        end else if (b[7:4] == SYSTEM_NIBBLE) begin
          shadow_phase = WAIT_DELAY;
          ev.kind = KIND_SYNC;
          ev.delay = shadow_delay;
          produced = 1'b1;
        end else if (b[7]) begin
          shadow_status = b;
          shadow_partial = {8'h00, b};
          shadow_phase = WAIT_DATA1;
        end else if (shadow_status == NO_STATUS) begin
          // A data byte without a running status is dropped.
          shadow_phase = WAIT_DELAY;
        end else begin
          shadow_partial = {b, shadow_status};
          if (takes_two_data(shadow_status)) begin
            shadow_phase = WAIT_DATA2;
          end else begin
            shadow_phase = WAIT_DELAY;
            ev.delay = shadow_delay;
            ev.message = {8'h00, shadow_partial};
            produced = 1'b1;
          end
        end
      end
      WAIT_DATA1: begin
        shadow_partial = {b, shadow_partial[7:0]};
        if (takes_two_data(shadow_partial[7:0])) begin
          shadow_phase = WAIT_DATA2;
        end else begin
          shadow_phase = WAIT_DELAY;
          ev.delay = shadow_delay;
          ev.message = {8'h00, shadow_partial};
          produced = 1'b1;
        end
      end
      WAIT_DATA2: begin
        shadow_phase = WAIT_DELAY;
        ev.delay = shadow_delay;
        ev.message = {b, shadow_partial};
        produced = 1'b1;
      end
      default: begin
        // Bytes after end of stream are absorbed.
      end
    endcase
    return produced;
  endfunction

  // Sends one item after a random gap and records the event it should produce.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    midi_event_t ev;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= restart;
    do @(posedge clk); while (in_tready !== 1'b1);
    bytes_sent++;
    if (parse_stream_byte(b, restart, ev)) pending_events.push_back(ev);
  endtask

  // Data byte, now and then with bit 7 set.
  function automatic logic [7:0] random_data();
    if ($urandom_range(15) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(DATA_LAST));
  endfunction

  // One event of a plausible song, with some noise and broken events mixed in.
  task automatic send_random_event();
    int unsigned pick;
    logic        restart;
    logic [7:0]  delay;
    logic [7:0]  status;
    restart = 1'b0;
    if (shadow_phase == STREAM_ENDED) begin
      repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 1'b0);
      restart = 1'b1;
    end
    pick = $urandom_range(99);
    delay = 8'($urandom_range(DELAY_SYNC_CODE - 1));
    if (pick < 6) begin
      // Noise, sometimes restarting the song in the middle of an event.
      send_byte(8'($urandom_range(255)), restart | ($urandom_range(3) == 0));
    end else if (pick < 12) begin
      send_byte(DELAY_SYNC_CODE, restart);
    end else if (pick < 19) begin
      send_byte(delay, restart);
      send_byte(8'($urandom_range(DELAY_END_CODE, SYSTEM_FIRST)), 1'b0);
    end else if (pick < 22) begin
      if (pick[0]) begin
        send_byte(DELAY_END_CODE, restart);
      end else begin
        send_byte(delay, restart);
        send_byte(CMD_END_CODE, 1'b0);
      end
    end else if (pick < 42) begin
      // Running status: data straight after the delay.
      send_byte(delay, restart);
      status = restart ? NO_STATUS : shadow_status;
      send_byte(8'($urandom_range(DATA_LAST)), 1'b0);
      if (status != NO_STATUS && takes_two_data(status)) send_byte(random_data(), 1'b0);
    end else begin
      status = 8'($urandom_range(STATUS_LAST, STATUS_FIRST));
      send_byte(delay, restart);
      send_byte(status, 1'b0);
      send_byte(random_data(), 1'b0);
      if (takes_two_data(status)) send_byte(random_data(), 1'b0);
    end
  endtask

  // Short messages with one and two data bytes, with and without running status.
  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'h90, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h05, 1'b0);
    // Status at the top of the range, data bytes with bit 7 set.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Sync events, both ends of stream, ignored bytes and a data byte with no status.
  task automatic test_sync_and_end();
    send_byte(DELAY_SYNC_CODE, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(SYSTEM_FIRST, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(CMD_END_CODE, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h90, 1'b0);
    // A restart drops the running status, so this data byte is lost.
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(DELAY_END_CODE, 1'b0);
    send_byte(DELAY_END_CODE, 1'b1);
  endtask

  // Random song content until the byte count reaches the goal.
  task automatic test_random_song(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned byte_goal);
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    while (bytes_sent < byte_goal) send_random_event();
  endtask

  // Result side stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Compares every accepted result with the oldest expected event.
  always @(posedge clk) begin
    midi_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: kind %0d delay 0x%02h message 0x%06h",
               out_tuser, out_tdata[7:0], out_tdata[31:8]);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_tuser !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_tuser);
          error_count++;
        end
        if (out_tdata[7:0] !== want.delay) begin
          $error("event_delay: expected 0x%02h, got 0x%02h", want.delay, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[31:8] !== want.message) begin
          $error("short_message: expected 0x%06h, got 0x%06h", want.message,
                 out_tdata[31:8]);
          error_count++;
        end
        case (want.kind)
          KIND_SHORT: short_seen++;
          KIND_SYNC: sync_seen++;
          default: end_seen++;
        endcase
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 29;
    receiver_idle_pct = 57;
    test_short_messages();
    test_sync_and_end();
    test_random_song(29, 57, 230);
    test_random_song(57, 29, 440);
    test_random_song(0, 0, 650);
    in_tvalid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d stream bytes under three idle patterns; checked %0d short, %0d sync",
             bytes_sent, short_seen, sync_seen);
    $display("and %0d end-of-stream events, %0d mismatches.", end_seen, error_count);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
